FILE: hw/rtl/rat_pkg.sv
// ----------------------------------------------------------------------------
// rat_pkg
// Shared types and constants of the row activation tracker.
// ----------------------------------------------------------------------------
package rat_pkg;

   localparam int BANKS      = 32;
   localparam int ENTRIES    = 16;
   localparam int ROWS       = 131072;
   localparam int COUNT_BITS = 16;

   localparam int BANK_W  = 5;
   localparam int ROW_W   = 17;
   localparam int ENT_W   = $clog2(ENTRIES);
   localparam int BSEL_W  = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int RAA_W   = 8;
   localparam int ATH_W   = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_A_W = 1;

   localparam logic [CSR_A_W-1:0] CSR_ACT_THRESH = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_RFM_THRESH = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // one table slot: valid, tag, count
   localparam int SLOT_W = 1 + ROW_W + COUNT_BITS;
   // per-bank row: all slots plus max, min pointers and activation counter
   localparam int BROW_W = ENTRIES * SLOT_W + 2 * ENT_W + RAA_W;

   typedef struct packed {
      logic                  vld;
      logic [ROW_W-1:0]      tag;
      logic [COUNT_BITS-1:0] cnt;
   } slot_type;

   typedef struct packed {
      slot_type [ENTRIES-1:0] slot;
      logic [ENT_W-1:0]       max_e;
      logic [ENT_W-1:0]       min_e;
      logic [RAA_W-1:0]       raa;
   } brow_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_UPDATE,
      ST_CHECK,
      ST_LEVEL,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                  fire;
      logic [BANK_W-1:0]     bank;
      logic [ROW_W-1:0]      row;
   } refresh_type;

endpackage

FILE: hw/rtl/rat_ram.sv
// ----------------------------------------------------------------------------
// rat_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;

endmodule

FILE: hw/rtl/rat_search.sv
// ----------------------------------------------------------------------------
// rat_search
// Lowest-index min and max search over the slots of one bank, registered.
// ----------------------------------------------------------------------------
module rat_search (
   input  logic                        clock,
   input  rat_pkg::brow_type           row_in,
   output logic [rat_pkg::ENT_W-1:0]   min_idx,
   output logic [rat_pkg::ENT_W-1:0]   max_idx
);
   import rat_pkg::*;

   // combinational tree, result registered: level 0 leaves, reduce pairwise
   localparam int LVL = ENT_W;

   logic [ENT_W-1:0] mn_t [LVL+1][ENTRIES];
   logic [ENT_W-1:0] mx_t [LVL+1][ENTRIES];
   logic [ENT_W-1:0] mn_ff, mx_ff;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         mn_t[0][i] = ENT_W'(i);
         mx_t[0][i] = ENT_W'(i);
      end
      for (int l = 1; l <= LVL; l++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            mn_t[l][i] = mn_t[l-1][i];
            mx_t[l][i] = mx_t[l-1][i];
         end
         for (int i = 0; i < (ENTRIES >> l); i++) begin
            mn_t[l][i] = (row_in.slot[mn_t[l-1][2*i+1]].cnt
                          < row_in.slot[mn_t[l-1][2*i]].cnt)
                         ? mn_t[l-1][2*i+1] : mn_t[l-1][2*i];
            mx_t[l][i] = (row_in.slot[mx_t[l-1][2*i+1]].cnt
                          > row_in.slot[mx_t[l-1][2*i]].cnt)
                         ? mx_t[l-1][2*i+1] : mx_t[l-1][2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      mn_ff <= mn_t[LVL][0];
      mx_ff <= mx_t[LVL][0];
   end

   assign min_idx = mn_ff;
   assign max_idx = mx_ff;

endmodule

FILE: hw/rtl/rowhammer_activation_tracker.sv
// ----------------------------------------------------------------------------
// rowhammer_activation_tracker
// Per-bank tagged activation counter table with victim refresh requests.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid/ready, is_activate, bank, row | in
//  rsp     | rsp_valid/ready, refresh valid/bank/row | out
//  csr     | csr_wr_en, csr_index, csr_wdata         | in
//
//  An activate passes through idle/accept, read, update (min search settles),
//  check, level (max search settles), write and present before the next one
//  is taken; rsp_valid is registered in present. The bank memory's single
//  port and the registered min/max search set that. An ignored item goes
//  straight from idle to present. After reset a clearing pass writes every
//  bank row while req_ready stays low.
//  The result waits in present until the output register is free; the next
//  item is taken in the idle cycle that follows.
// ----------------------------------------------------------------------------
module rowhammer_activation_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_is_activate,
   input  logic [rat_pkg::BANK_W-1:0]    req_bank_index,
   input  logic [rat_pkg::ROW_W-1:0]     req_row_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_refresh_valid,
   output logic [rat_pkg::BANK_W-1:0]    rsp_refresh_bank,
   output logic [rat_pkg::ROW_W-1:0]     rsp_refresh_row,
   input  logic                          csr_wr_en,
   input  logic [rat_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [rat_pkg::CSR_W-1:0]     csr_wdata
);
   import rat_pkg::*;

   state_type state_ff, state_in;

   logic [ATH_W-1:0]  ath_ff;
   logic [RAA_W-1:0]  rth_ff;
   logic [BSEL_W-1:0] clr_ff, clr_in;
   logic [BANK_W-1:0] bank_ff;
   logic [ROW_W-1:0]  row_ff;
   brow_type          work_ff, work_in;
   logic              chk_ff, chk_in;
   logic              rv_ff, rv_in;
   refresh_type       res_ff, res_in;

   brow_type          rd_row, wr_row;
   logic              mem_we;
   logic [BSEL_W-1:0] mem_addr;
   logic [ENT_W-1:0]  s_min, s_max;

   logic              accept, in_range;

   assign accept   = req_valid && req_ready;
   assign in_range = req_is_activate && (32'(req_bank_index) < BANKS)
                     && (32'(req_row_address) < ROWS);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ath_ff <= ATH_W'(512);
         rth_ff <= RAA_W'(64);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACT_THRESH: ath_ff <= csr_wdata[ATH_W-1:0];
            CSR_RFM_THRESH: rth_ff <= csr_wdata[RAA_W-1:0];
            default: ;
         endcase
      end
   end

   rat_ram #(.WIDTH(BROW_W), .DEPTH(BANKS > 1 ? BANKS : 2)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (wr_row),
      .rd_data (rd_row)
   );

   rat_search u_search (
      .clock   (clock),
      .row_in  (work_ff),
      .min_idx (s_min),
      .max_idx (s_max)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (32'(clr_ff) == BANKS - 1) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = in_range ? ST_READ : ST_OUT;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_LEVEL;
         ST_LEVEL:  state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_OUT;
         ST_OUT:    if (!rv_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [ENT_W-1:0]      hit_e, mn, mx;
      logic                  hit;
      logic [COUNT_BITS-1:0] c, cmax, cmin;
      logic [RAA_W-1:0]      raa;
      work_in  = work_ff;
      chk_in   = chk_ff;
      res_in   = res_ff;
      rv_in    = rv_ff;
      clr_in   = clr_ff;
      mem_we   = 1'b0;
      mem_addr = bank_ff[BSEL_W-1:0];
      wr_row   = work_ff;
      req_ready = 1'b0;
      hit_e = '0;
      hit   = 1'b0;
      mn = work_ff.min_e;
      mx = work_ff.max_e;
      c = '0; cmax = '0; cmin = '0; raa = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            wr_row   = '0;
            clr_in   = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_addr  = req_bank_index[BSEL_W-1:0];
            res_in    = '0;
         end
         ST_READ: begin
            // hit search, count update, pointer update
            work_in = rd_row;
            for (int e = ENTRIES - 1; e >= 0; e--) begin
               if (rd_row.slot[e].vld && rd_row.slot[e].tag == row_ff) begin
                  hit   = 1'b1;
                  hit_e = ENT_W'(e);
               end
            end
            mn = rd_row.min_e;
            mx = rd_row.max_e;
            raa = rd_row.raa + 1'b1;
            if (!hit) begin
               c = rd_row.slot[mn].cnt;
               work_in.slot[mn].tag = row_ff;
               work_in.slot[mn].vld = 1'b1;
               work_in.slot[mn].cnt = (c != COUNT_MAX) ? c + 1'b1 : c;
               chk_in = 1'b0;
            end else begin
               c = rd_row.slot[hit_e].cnt;
               if (c != COUNT_MAX) c = c + 1'b1;
               work_in.slot[hit_e].cnt = c;
               if (c > rd_row.slot[mx].cnt) work_in.max_e = hit_e;
               // min needs re-search if hit was the min entry
               chk_in = (hit_e == mn);
            end
            work_in.raa = raa;
         end
         ST_UPDATE, ST_LEVEL: begin
            // hold while the registered search catches up with work_ff
         end
         ST_CHECK: begin
            mx   = work_ff.max_e;
            mn   = chk_ff ? s_min : work_ff.min_e;
            work_in.min_e = mn;
            chk_in = 1'b0;
            cmax = work_ff.slot[mx].cnt;
            cmin = work_ff.slot[mn].cnt;
            if (work_ff.raa == rth_ff) begin
               work_in.raa = '0;
               if (work_ff.slot[mx].vld && cmax >= cmin
                   && (cmax - cmin) >= ath_ff) begin
                  res_in.fire = 1'b1;
                  res_in.bank = bank_ff;
                  res_in.row  = work_ff.slot[mx].tag;
                  work_in.slot[mx].cnt = cmin;
                  chk_in = 1'b1;
               end
            end
         end
         ST_WRITE: begin
            if (chk_ff) work_in.max_e = s_max;
            wr_row.max_e = chk_ff ? s_max : work_ff.max_e;
            mem_we = 1'b1;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         chk_ff   <= chk_in;
      end
   end

   // payload: hold the result until the output register is loaded
   refresh_type out_ff;
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      res_ff  <= res_in;
      if (accept) begin
         bank_ff <= req_bank_index;
         row_ff  <= req_row_address;
      end
      if (state_ff == ST_OUT && (!rv_ff || rsp_ready)) out_ff <= res_ff;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_refresh_valid = out_ff.fire;
   assign rsp_refresh_bank  = out_ff.bank;
   assign rsp_refresh_row   = out_ff.row;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input accepted while busy");
   a_write_after_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEVEL) |=> mem_we)
      else $error("bank row not written back");
   a_refresh_bank: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && out_ff.fire) |-> (32'(out_ff.bank) < BANKS))
      else $error("refresh bank out of range");

endmodule

FILE: dv/tb_rowhammer_activation_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rowhammer_activation_tracker
// Self-checking bench for the per-bank row activation tracker. A queue of
// activates (hot rows in a few banks, plus noise and non-activates) feeds a
// handshake driver; a bit-accurate table predictor runs on every accepted
// transfer, and a monitor compares each response transfer against it.
// Threshold registers are swept across several settings between phases.
// ----------------------------------------------------------------------------
module tb_rowhammer_activation_tracker;
   import rat_pkg::*;

   typedef struct packed {
      logic              act;
      logic [BANK_W-1:0] bank;
      logic [ROW_W-1:0]  row;
   } activate_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int STALL_START    = 6000;
   localparam int STALL_LEN      = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_is_activate = 1'b0;
   logic [BANK_W-1:0]   req_bank_index = '0;
   logic [ROW_W-1:0]    req_row_address = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_refresh_valid;
   logic [BANK_W-1:0]   rsp_refresh_bank;
   logic [ROW_W-1:0]    rsp_refresh_row;
   logic                csr_wr_en = 1'b0;
   logic [CSR_A_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   rowhammer_activation_tracker uut (.*);

   always #6 clock = ~clock;

   // shadow of the tracker state and its registers
   logic [ROW_W-1:0]      tag_sh [BANKS][ENTRIES];
   bit                    vld_sh [BANKS][ENTRIES];
   logic [COUNT_BITS-1:0] cnt_sh [BANKS][ENTRIES];
   int unsigned           max_sh [BANKS];
   int unsigned           min_sh [BANKS];
   logic [RAA_W-1:0]      raa_sh [BANKS];
   logic [ATH_W-1:0]      act_thresh_sh = 16'd512;
   logic [RAA_W-1:0]      rfm_thresh_sh = 8'd64;

   activate_type pending_acts[$];
   refresh_type  expected_refreshes[$];
   int           fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  quiet_cycles = 0;

   initial begin
      for (int b = 0; b < BANKS; b++) begin
         max_sh[b] = 0;
         min_sh[b] = 0;
         raa_sh[b] = '0;
         for (int e = 0; e < ENTRIES; e++) begin
            tag_sh[b][e] = '0;
            vld_sh[b][e] = 1'b0;
            cnt_sh[b][e] = '0;
         end
      end
   end

   // Advance the shadow table by one activate and return the refresh it causes.
   function automatic refresh_type track_activate(input activate_type a);
      refresh_type           res;
      int unsigned           hit, mx, mn, b;
      logic [COUNT_BITS-1:0] cmax, cmin;
      res = '0;
      if (!a.act) return res;
      b   = a.bank;
      mx  = max_sh[b];
      mn  = min_sh[b];
      hit = ENTRIES;
      raa_sh[b] = raa_sh[b] + 1'b1;
      for (int e = ENTRIES - 1; e >= 0; e--)
         if (vld_sh[b][e] && tag_sh[b][e] == a.row) hit = e;
      if (hit == ENTRIES) begin
         // miss: take over the min slot
         tag_sh[b][mn] = a.row;
         vld_sh[b][mn] = 1'b1;
         if (cnt_sh[b][mn] != COUNT_MAX) cnt_sh[b][mn] = cnt_sh[b][mn] + 1'b1;
      end else begin
         if (cnt_sh[b][hit] != COUNT_MAX) cnt_sh[b][hit] = cnt_sh[b][hit] + 1'b1;
         if (cnt_sh[b][hit] > cnt_sh[b][mx]) max_sh[b] = hit;
         if (hit == mn) begin
            min_sh[b] = 0;
            for (int e = 1; e < ENTRIES; e++)
               if (cnt_sh[b][e] < cnt_sh[b][min_sh[b]]) min_sh[b] = e;
         end
      end
      if (raa_sh[b] == rfm_thresh_sh) begin
         raa_sh[b] = '0;
         mx   = max_sh[b];
         cmax = cnt_sh[b][mx];
         cmin = cnt_sh[b][min_sh[b]];
         if (vld_sh[b][mx] && cmax >= cmin && (cmax - cmin) >= act_thresh_sh) begin
            res.fire = 1'b1;
            res.bank = a.bank;
            res.row  = tag_sh[b][mx];
            cnt_sh[b][mx] = cmin;
            max_sh[b] = 0;
            for (int e = 1; e < ENTRIES; e++)
               if (cnt_sh[b][e] > cnt_sh[b][max_sh[b]]) max_sh[b] = e;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Idling is suppressed in one long stretch so back-to-back transfers occur.
   function automatic bit take_a_break();
      if (cycle_count >= 2000 && cycle_count < 4000) return 1'b0;
      return $urandom_range(99) < 16;
   endfunction

   // Driver: hold the payload until accepted, then advance to the next activate.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_refreshes = {expected_refreshes, track_activate(
               '{req_is_activate, req_bank_index, req_row_address})};
         if (!req_valid || req_ready) begin
            if (pending_acts.size() > 0 && !take_a_break()) begin
               activate_type nxt;
               nxt = pending_acts.pop_front();
               req_valid       <= 1'b1;
               req_is_activate <= nxt.act;
               req_bank_index  <= nxt.bank;
               req_row_address <= nxt.row;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response transfer with the oldest predicted refresh.
   // Drop ready for one long stretch so the tracker backs up into its input.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_refreshes.size() == 0) begin
               report_mismatch("unexpected response", 32'd1, 32'd0);
            end else begin
               refresh_type want;
               want = expected_refreshes.pop_front();
               if (rsp_refresh_valid !== want.fire)
                  report_mismatch("refresh_valid", rsp_refresh_valid, want.fire);
               if (rsp_refresh_bank !== want.bank)
                  report_mismatch("refresh_bank", rsp_refresh_bank, want.bank);
               if (rsp_refresh_row !== want.row)
                  report_mismatch("refresh_row", rsp_refresh_row, want.row);
            end
         end
         if (cycle_count >= STALL_START && cycle_count < STALL_START + STALL_LEN)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= !take_a_break();
      end
   end

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_A_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_ACT_THRESH) act_thresh_sh = val;
      else rfm_thresh_sh = val[RAA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait for every queued activate to go out and every response to return.
   task automatic drain();
      while (pending_acts.size() > 0 || req_valid || expected_refreshes.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Queue hammering traffic: hot rows in a few banks, with some noise.
   task automatic queue_hammer(input int count);
      logic [BANK_W-1:0] hot_banks[4];
      logic [ROW_W-1:0]  hot_rows[24];
      activate_type      a;
      int                pick;
      foreach (hot_banks[i]) hot_banks[i] = BANK_W'($urandom);
      foreach (hot_rows[i]) hot_rows[i] = ROW_W'($urandom);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         a.act  = 1'b1;
         a.bank = hot_banks[$urandom_range(3)];
         if (pick < 40)      a.row = hot_rows[$urandom_range(2)];
         else if (pick < 85) a.row = hot_rows[$urandom_range(23)];
         else if (pick < 93) begin
            a.row  = ROW_W'($urandom);
            a.bank = BANK_W'($urandom);
         end else begin
            a.act  = 1'b0;
            a.bank = BANK_W'($urandom);
            a.row  = ROW_W'($urandom);
         end
         pending_acts = {pending_acts, a};
      end
   endtask

   // Append one directed activate to the pending queue.
   task automatic queue_one(input logic act, input logic [BANK_W-1:0] bank,
                            input logic [ROW_W-1:0] row);
      activate_type a;
      a.act  = act;
      a.bank = bank;
      a.row  = row;
      pending_acts = {pending_acts, a};
   endtask

   initial begin
      logic [ATH_W-1:0] ath_set[8] = '{16'd2, 16'd0, 16'd1, 16'd65535,
                                       16'd3, 16'd1, 16'd6, 16'd512};
      logic [RAA_W-1:0] rfm_set[8] = '{8'd4, 8'd1, 8'd0, 8'd255,
                                       8'd8, 8'd1, 8'd16, 8'd64};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, two non-activates, and one row hammered to refresh
      write_csr(CSR_ACT_THRESH, 16'd1);
      write_csr(CSR_RFM_THRESH, 16'd2);
      queue_one(1'b1, 5'd0, 17'd0);
      queue_one(1'b1, 5'd31, 17'h1FFFF);
      queue_one(1'b0, 5'd31, 17'h1FFFF);
      queue_one(1'b1, 5'd31, 17'h1FFFF);
      queue_one(1'b1, 5'd0, 17'h1FFFF);
      queue_one(1'b1, 5'd31, 17'd0);
      for (int i = 0; i < 12; i++)
         queue_one(1'b1, 5'd7, (i % 4 == 3) ? 17'h0AAAA : 17'h15555);
      queue_one(1'b0, 5'd0, 17'd0);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_ACT_THRESH, ath_set[p]);
         write_csr(CSR_RFM_THRESH, CSR_W'(rfm_set[p]));
         queue_hammer(p == 2 ? 400 : 220);
         drain();
      end

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
